FILE: sv/dihed_pkg.sv
// shared widths, types, constants and the cordic arctangent table for the torsion angle pipeline
package dihed_pkg;

  localparam int COORD_WIDTH_DEFAULT = 32;
  localparam int ANGLE_FRAC_DEFAULT  = 17;

  // bond and normal vectors are rescaled to this many magnitude bits
  localparam int VEC_BITS = 20;
  localparam int SV_W     = VEC_BITS + 1;
  localparam int CR_W     = 2 * SV_W + 1;
  localparam int BB_W     = 2 * SV_W;
  localparam int RT_W     = BB_W / 2;
  localparam int NUM_W    = 64;

  // cordic operand scaling and datapath widths
  localparam int PAIR_BITS    = 29;
  localparam int PS_W         = PAIR_BITS + 1;
  localparam int CX_W         = 33;
  localparam int CZ_W         = 36;
  localparam int CORDIC_STEPS = 32;
  localparam int CORDIC_PER   = 2;
  localparam int SQ_PER       = 3;

  localparam logic signed [CZ_W-1:0] PI_Q32 = 36'sd13493037704;

  typedef logic signed [SV_W-1:0] svec_t [3];
  typedef logic signed [CR_W-1:0] cvec_t [3];

  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic signed [CR_W-1:0]  uv;
    logic                    degen;
  } sq_side_t;

  typedef struct packed {
    logic degen;
    logic num_zero;
    logic den_neg;
  } cd_side_t;

  // atan(2^-i) in Q32
  function automatic logic signed [CZ_W-1:0] atan_q32(input logic [4:0] i);
    logic signed [CZ_W-1:0] r;
    case (i)
      5'd0:  r = 36'sd3373259426;
      5'd1:  r = 36'sd1991351318;
      5'd2:  r = 36'sd1052175346;
      5'd3:  r = 36'sd534100635;
      5'd4:  r = 36'sd268086748;
      5'd5:  r = 36'sd134174063;
      5'd6:  r = 36'sd67103403;
      5'd7:  r = 36'sd33553749;
      5'd8:  r = 36'sd16777131;
      5'd9:  r = 36'sd8388597;
      5'd10: r = 36'sd4194303;
      5'd11: r = 36'sd2097152;
      5'd12: r = 36'sd1048576;
      5'd13: r = 36'sd524288;
      5'd14: r = 36'sd262144;
      5'd15: r = 36'sd131072;
      5'd16: r = 36'sd65536;
      5'd17: r = 36'sd32768;
      5'd18: r = 36'sd16384;
      5'd19: r = 36'sd8192;
      5'd20: r = 36'sd4096;
      5'd21: r = 36'sd2048;
      5'd22: r = 36'sd1024;
      5'd23: r = 36'sd512;
      5'd24: r = 36'sd256;
      5'd25: r = 36'sd128;
      5'd26: r = 36'sd64;
      5'd27: r = 36'sd32;
      5'd28: r = 36'sd16;
      5'd29: r = 36'sd8;
      5'd30: r = 36'sd4;
      5'd31: r = 36'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/dihedral_angle_four_points_core.sv
// top level: signed torsion angle of four points about the b-c bond, fully pipelined
// throughput: one beat per cycle; busy is always low and start may be high every cycle
// the depth is set by the square root (7 stages) and the 32-step cordic (16 stages)
// reset (rst, synchronous) clears every valid bit; beats in flight are dropped, done goes low
// results are not held: each appears on torsion/degenerate for the single cycle done is high
module dihedral_angle_four_points_core #(
  parameter int COORD_WIDTH     = dihed_pkg::COORD_WIDTH_DEFAULT,
  parameter int ANGLE_FRAC_BITS = dihed_pkg::ANGLE_FRAC_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [COORD_WIDTH-1:0]  ax,
  input  logic signed [COORD_WIDTH-1:0]  ay,
  input  logic signed [COORD_WIDTH-1:0]  az,
  input  logic signed [COORD_WIDTH-1:0]  bx,
  input  logic signed [COORD_WIDTH-1:0]  by,
  input  logic signed [COORD_WIDTH-1:0]  bz,
  input  logic signed [COORD_WIDTH-1:0]  cx,
  input  logic signed [COORD_WIDTH-1:0]  cy,
  input  logic signed [COORD_WIDTH-1:0]  cz,
  input  logic signed [COORD_WIDTH-1:0]  dx,
  input  logic signed [COORD_WIDTH-1:0]  dy,
  input  logic signed [COORD_WIDTH-1:0]  dz,
  output logic                           done,
  output logic signed [ANGLE_FRAC_BITS+2:0] torsion,
  output logic                           degenerate
);

  localparam int DW    = COORD_WIDTH + 1;
  localparam int SV_W  = dihed_pkg::SV_W;
  localparam int CR_W  = dihed_pkg::CR_W;
  localparam int BB_W  = dihed_pkg::BB_W;
  localparam int RT_W  = dihed_pkg::RT_W;
  localparam int NUM_W = dihed_pkg::NUM_W;
  localparam int PS_W  = dihed_pkg::PS_W;
  localparam int CX_W  = dihed_pkg::CX_W;
  localparam int CZ_W  = dihed_pkg::CZ_W;
  localparam int TW    = ANGLE_FRAC_BITS + 3;
  localparam int SQ_SW = $bits(dihed_pkg::sq_side_t);
  localparam int CD_SW = $bits(dihed_pkg::cd_side_t);

  // r0 = p1*q2 - p2*q1 style term of a cross product
  function automatic logic signed [CR_W-1:0] cross_c(
    input logic signed [SV_W-1:0] p0, p1, q0, q1);
    logic signed [2*SV_W-1:0] m0;
    logic signed [2*SV_W-1:0] m1;
    m0 = p0 * q1;
    m1 = p1 * q0;
    return CR_W'(m0) - CR_W'(m1);
  endfunction

  function automatic logic signed [2*SV_W+1:0] dot_s(
    input dihed_pkg::svec_t p, input dihed_pkg::svec_t q);
    logic signed [2*SV_W-1:0] m;
    logic signed [2*SV_W+1:0] acc;
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      m   = p[i] * q[i];
      acc = acc + (2*SV_W+2)'(m);
    end
    return acc;
  endfunction

  function automatic logic signed [NUM_W+1:0] dot_w(
    input dihed_pkg::cvec_t p, input dihed_pkg::svec_t q);
    logic signed [NUM_W-1:0] m;
    logic signed [NUM_W+1:0] acc;
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      m   = p[i] * q[i];
      acc = acc + (NUM_W+2)'(m);
    end
    return acc;
  endfunction

  // every stage accepts a new beat each cycle and nothing stalls
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // stage 1: bond vectors b1 = b-a, b2 = c-b, b3 = d-c, exact
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] d1 [3];
  logic signed [DW-1:0] d2 [3];
  logic signed [DW-1:0] d3 [3];
  logic                 vld1, vld2, vld3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
    end else begin
      vld1 <= start;
      vld2 <= vld1;
      vld3 <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    d1[0] <= DW'(bx) - DW'(ax);
    d1[1] <= DW'(by) - DW'(ay);
    d1[2] <= DW'(bz) - DW'(az);
    d2[0] <= DW'(cx) - DW'(bx);
    d2[1] <= DW'(cy) - DW'(by);
    d2[2] <= DW'(cz) - DW'(bz);
    d3[0] <= DW'(dx) - DW'(cx);
    d3[1] <= DW'(dy) - DW'(cy);
    d3[2] <= DW'(dz) - DW'(cz);
  end

  // stages 2-3: each bond vector scaled to VEC_BITS magnitude bits
  dihed_pkg::svec_t s1v, s2v, s3v;
  logic             z1, z2, z3;

  dihed_scale #(.N(3), .IW(DW), .OW(dihed_pkg::VEC_BITS)) u_scale_b1 (
    .clk(clk), .din(d1), .dout(s1v), .zero(z1));
  dihed_scale #(.N(3), .IW(DW), .OW(dihed_pkg::VEC_BITS)) u_scale_b2 (
    .clk(clk), .din(d2), .dout(s2v), .zero(z2));
  dihed_scale #(.N(3), .IW(DW), .OW(dihed_pkg::VEC_BITS)) u_scale_b3 (
    .clk(clk), .din(d3), .dout(s3v), .zero(z3));

  // ---------------------------------------------------------------------------
  // stage 4: normals U = b1 x b2, V = b2 x b3, and |b2|^2
  // ---------------------------------------------------------------------------
  dihed_pkg::cvec_t  uu4, vv4;
  dihed_pkg::svec_t  b2_4, b2_5, b2_6;
  logic [BB_W-1:0]   bb4, bb5, bb6;
  logic              dg4, dg5, dg6;
  logic              vld4, vld5, vld6;
  logic [2*SV_W+1:0] bb_full;

  assign bb_full = dot_s(s2v, s2v);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld4 <= 1'b0;
      vld5 <= 1'b0;
      vld6 <= 1'b0;
    end else begin
      vld4 <= vld3;
      vld5 <= vld4;
      vld6 <= vld5;
    end
  end

  always_ff @(posedge clk) begin
    uu4[0] <= cross_c(s1v[1], s1v[2], s2v[1], s2v[2]);
    uu4[1] <= cross_c(s1v[2], s1v[0], s2v[2], s2v[0]);
    uu4[2] <= cross_c(s1v[0], s1v[1], s2v[0], s2v[1]);
    vv4[0] <= cross_c(s2v[1], s2v[2], s3v[1], s3v[2]);
    vv4[1] <= cross_c(s2v[2], s2v[0], s3v[2], s3v[0]);
    vv4[2] <= cross_c(s2v[0], s2v[1], s3v[0], s3v[1]);
    bb4    <= bb_full[BB_W-1:0];
    b2_4   <= s2v;
    dg4    <= z1 | z2 | z3;
    b2_5   <= b2_4;
    bb5    <= bb4;
    dg5    <= dg4;
    b2_6   <= b2_5;
    bb6    <= bb5;
    dg6    <= dg5;
  end

  // stages 5-6: normals scaled; a zero normal means a collinear triple
  dihed_pkg::svec_t us6, vs6;
  logic             zu6, zv6;

  dihed_scale #(.N(3), .IW(CR_W), .OW(dihed_pkg::VEC_BITS)) u_scale_u (
    .clk(clk), .din(uu4), .dout(us6), .zero(zu6));
  dihed_scale #(.N(3), .IW(CR_W), .OW(dihed_pkg::VEC_BITS)) u_scale_v (
    .clk(clk), .din(vv4), .dout(vs6), .zero(zv6));

  // ---------------------------------------------------------------------------
  // stage 7: W = U x V and U.V; stage 8: numerator W.b2
  // ---------------------------------------------------------------------------
  dihed_pkg::cvec_t        ww7;
  logic signed [CR_W-1:0]  uv7, uv8;
  dihed_pkg::svec_t        b2_7;
  logic [BB_W-1:0]         bb7, bb8;
  logic                    dg7, dg8;
  logic                    vld7, vld8;
  logic signed [NUM_W-1:0] num8;
  logic [2*SV_W+1:0]       uv_full;
  logic [NUM_W+1:0]        num_full;

  assign uv_full  = dot_s(us6, vs6);
  assign num_full = dot_w(ww7, b2_7);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld7 <= 1'b0;
      vld8 <= 1'b0;
    end else begin
      vld7 <= vld6;
      vld8 <= vld7;
    end
  end

  always_ff @(posedge clk) begin
    ww7[0] <= cross_c(us6[1], us6[2], vs6[1], vs6[2]);
    ww7[1] <= cross_c(us6[2], us6[0], vs6[2], vs6[0]);
    ww7[2] <= cross_c(us6[0], us6[1], vs6[0], vs6[1]);
    uv7    <= uv_full[CR_W-1:0];
    b2_7   <= b2_6;
    bb7    <= bb6;
    dg7    <= dg6 | zu6 | zv6;
    num8   <= num_full[NUM_W-1:0];
    uv8    <= uv7;
    bb8    <= bb7;
    dg8    <= dg7;
  end

  // stages 9-15: |b2| as the floor square root, numerator and U.V ride along
  dihed_pkg::sq_side_t sq_in, sq_out;
  logic [SQ_SW-1:0]    sq_out_raw;
  logic [RT_W-1:0]     root15;
  logic                vld15;

  assign sq_in = '{num: num8, uv: uv8, degen: dg8};

  dihed_isqrt #(.SW(SQ_SW)) u_isqrt (
    .clk(clk), .rst(rst), .in_valid(vld8), .radicand(bb8), .in_side(sq_in),
    .out_valid(vld15), .root(root15), .out_side(sq_out_raw));

  assign sq_out = dihed_pkg::sq_side_t'(sq_out_raw);

  // ---------------------------------------------------------------------------
  // stage 16: denominator U.V * |b2|
  // ---------------------------------------------------------------------------
  logic signed [CR_W+RT_W:0] den_full;
  logic signed [NUM_W-1:0]   den16, num16;
  logic                      nz16, nz17, nz18;
  logic                      dg16, dg17, dg18;
  logic                      vld16, vld17, vld18;

  assign den_full = sq_out.uv * $signed({1'b0, root15});

  always_ff @(posedge clk) begin
    if (rst) begin
      vld16 <= 1'b0;
      vld17 <= 1'b0;
      vld18 <= 1'b0;
    end else begin
      vld16 <= vld15;
      vld17 <= vld16;
      vld18 <= vld17;
    end
  end

  always_ff @(posedge clk) begin
    den16 <= den_full[NUM_W-1:0];
    num16 <= sq_out.num;
    nz16  <= (sq_out.num == '0);
    dg16  <= sq_out.degen;
    nz17  <= nz16;
    dg17  <= dg16;
    nz18  <= nz17;
    dg18  <= dg17;
  end

  // stages 17-18: the (den, num) pair scaled jointly for the cordic
  logic signed [NUM_W-1:0] pair_in  [2];
  logic signed [PS_W-1:0]  pair_out [2];
  logic                    pz18;

  assign pair_in[0] = den16;
  assign pair_in[1] = num16;

  dihed_scale #(.N(2), .IW(NUM_W), .OW(dihed_pkg::PAIR_BITS)) u_scale_pair (
    .clk(clk), .din(pair_in), .dout(pair_out), .zero(pz18));

  // ---------------------------------------------------------------------------
  // stage 19: fold the left half-plane onto the right, start angle +-pi
  // ---------------------------------------------------------------------------
  logic signed [CX_W-1:0] xe, ye;
  logic signed [CX_W-1:0] cx19, cy19;
  logic signed [CZ_W-1:0] cz19;
  dihed_pkg::cd_side_t    cd19;
  logic                   vld19;

  assign xe = CX_W'(pair_out[0]);
  assign ye = CX_W'(pair_out[1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld19 <= 1'b0;
    end else begin
      vld19 <= vld18;
    end
  end

  always_ff @(posedge clk) begin
    if (xe < 0) begin
      cx19 <= -xe;
      cy19 <= -ye;
      cz19 <= (ye >= 0) ? dihed_pkg::PI_Q32 : -dihed_pkg::PI_Q32;
    end else begin
      cx19 <= xe;
      cy19 <= ye;
      cz19 <= '0;
    end
    // an all-zero pair only arises with a zero numerator
    cd19 <= '{degen: dg18, num_zero: nz18 | pz18, den_neg: xe < 0};
  end

  // stages 20-35: cordic
  logic signed [CZ_W-1:0] z35;
  logic [CD_SW-1:0]       cd35_raw;
  dihed_pkg::cd_side_t    cd35;
  logic                   vld35;

  dihed_cordic #(.SW(CD_SW)) u_cordic (
    .clk(clk), .rst(rst), .in_valid(vld19), .x_in(cx19), .y_in(cy19), .z_in(cz19),
    .in_side(cd19), .out_valid(vld35), .z_out(z35), .out_side(cd35_raw));

  assign cd35 = dihed_pkg::cd_side_t'(cd35_raw);

  // ---------------------------------------------------------------------------
  // stage 36: clamp to [-pi, pi], round half up to ANGLE_FRAC_BITS, output beat
  // ---------------------------------------------------------------------------
  logic signed [CZ_W-1:0] zsel;
  logic signed [CZ_W:0]   rnd;
  logic signed [CZ_W:0]   ang;
  logic [CZ_W:0]          half;
  logic signed [TW-1:0]   torsion_next;

  always_comb begin
    if (cd35.num_zero) begin
      zsel = cd35.den_neg ? dihed_pkg::PI_Q32 : '0;
    end else if (z35 > dihed_pkg::PI_Q32) begin
      zsel = dihed_pkg::PI_Q32;
    end else if (z35 < -dihed_pkg::PI_Q32) begin
      zsel = -dihed_pkg::PI_Q32;
    end else begin
      zsel = z35;
    end
    half = (CZ_W+1)'(1) << (31 - ANGLE_FRAC_BITS);
    rnd  = {zsel[CZ_W-1], zsel} + half;
    ang  = rnd >>> (32 - ANGLE_FRAC_BITS);
    torsion_next = cd35.degen ? '0 : ang[TW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld35;
    end
  end

  always_ff @(posedge clk) begin
    torsion    <= torsion_next;
    degenerate <= cd35.degen;
  end

endmodule

FILE: sv/dihed_scale.sv
// two-stage block scaler: shifts a group of values so the largest magnitude has OW bits
module dihed_scale #(
  parameter int N  = 3,
  parameter int IW = 33,
  parameter int OW = 20
) (
  input  logic                 clk,
  input  logic signed [IW-1:0] din  [N],
  output logic signed [OW:0]   dout [N],
  output logic                 zero
);

  localparam int LW = $clog2(IW + 1);
  localparam int EW = (IW > OW ? IW : OW) + 1;

  logic signed [IW-1:0] held [N];
  logic [LW-1:0]        len;
  logic [LW-1:0]        len_next;
  logic [IW-1:0]        mag_or;
  logic signed [OW:0]   dout_next [N];

  // bit length of the largest magnitude equals that of the or of all magnitudes
  always_comb begin
    mag_or   = '0;
    len_next = '0;
    for (int i = 0; i < N; i++) begin
      mag_or = mag_or | (din[i][IW-1] ? IW'(-din[i]) : IW'(din[i]));
    end
    for (int b = 0; b < IW; b++) begin
      if (mag_or[b]) len_next = LW'(b + 1);
    end
  end

  always_ff @(posedge clk) begin
    held <= din;
    len  <= len_next;
  end

  always_comb begin
    logic signed [EW-1:0] ext;
    logic signed [EW-1:0] sh;
    for (int i = 0; i < N; i++) begin
      ext = {{(EW - IW){held[i][IW-1]}}, held[i]};
      if (int'(len) > OW) sh = ext >>> (int'(len) - OW);
      else                sh = ext <<< (OW - int'(len));
      dout_next[i] = sh[OW:0];
    end
  end

  always_ff @(posedge clk) begin
    dout <= dout_next;
    zero <= (len == '0);
  end

endmodule

FILE: sv/dihed_isqrt.sv
// pipelined floor square root, a few result bits per stage, side data carried alongside
module dihed_isqrt #(
  parameter int SW = 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [dihed_pkg::BB_W-1:0]     radicand,
  input  logic [SW-1:0]                  in_side,
  output logic                           out_valid,
  output logic [dihed_pkg::RT_W-1:0]     root,
  output logic [SW-1:0]                  out_side
);

  localparam int BW     = dihed_pkg::BB_W;
  localparam int NSTEP  = dihed_pkg::RT_W;
  localparam int PER    = dihed_pkg::SQ_PER;
  localparam int STAGES = (NSTEP + PER - 1) / PER;
  localparam int RW     = BW + 1;

  logic [BW-1:0] rem_q  [STAGES];
  logic [RW-1:0] res_q  [STAGES];
  logic          vld_q  [STAGES];
  logic [SW-1:0] side_q [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_st
    logic [BW-1:0] rem_in;
    logic [RW-1:0] res_in;
    logic          vld_in;
    logic [SW-1:0] side_in;
    logic [BW-1:0] rem_next;
    logic [RW-1:0] res_next;

    if (s == 0) begin : g_first
      assign rem_in  = radicand;
      assign res_in  = '0;
      assign vld_in  = in_valid;
      assign side_in = in_side;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign res_in  = res_q[s-1];
      assign vld_in  = vld_q[s-1];
      assign side_in = side_q[s-1];
    end

    always_comb begin
      logic [RW-1:0] bitv;
      logic [RW-1:0] trial;
      rem_next = rem_in;
      res_next = res_in;
      bitv     = '0;
      trial    = '0;
      for (int j = 0; j < PER; j++) begin
        if (s * PER + j < NSTEP) begin
          bitv  = RW'(1) << (BW - 2 - 2 * (s * PER + j));
          trial = res_next + bitv;
          if ({1'b0, rem_next} >= trial) begin
            rem_next = rem_next - trial[BW-1:0];
            res_next = (res_next >> 1) + bitv;
          end else begin
            res_next = res_next >> 1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_q[s]  <= rem_next;
      res_q[s]  <= res_next;
      side_q[s] <= side_in;
    end
  end

  assign out_valid = vld_q[STAGES-1];
  assign root      = res_q[STAGES-1][NSTEP-1:0];
  assign out_side  = side_q[STAGES-1];

endmodule

FILE: sv/dihed_cordic.sv
// pipelined vectoring cordic, a fixed number of iterations per stage
module dihed_cordic #(
  parameter int SW = 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic signed [dihed_pkg::CX_W-1:0]     x_in,
  input  logic signed [dihed_pkg::CX_W-1:0]     y_in,
  input  logic signed [dihed_pkg::CZ_W-1:0]     z_in,
  input  logic [SW-1:0]                         in_side,
  output logic                                  out_valid,
  output logic signed [dihed_pkg::CZ_W-1:0]     z_out,
  output logic [SW-1:0]                         out_side
);

  localparam int XW     = dihed_pkg::CX_W;
  localparam int ZW     = dihed_pkg::CZ_W;
  localparam int PER    = dihed_pkg::CORDIC_PER;
  localparam int STAGES = dihed_pkg::CORDIC_STEPS / PER;

  // the last stage keeps only the angle
  logic signed [XW-1:0] x_q    [STAGES-1];
  logic signed [XW-1:0] y_q    [STAGES-1];
  logic signed [ZW-1:0] z_q    [STAGES];
  logic                 vld_q  [STAGES];
  logic [SW-1:0]        side_q [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_st
    logic signed [XW-1:0] x_cur;
    logic signed [XW-1:0] y_cur;
    logic signed [ZW-1:0] z_cur;
    logic                 vld_in;
    logic [SW-1:0]        side_in;
    logic signed [XW-1:0] x_next;
    logic signed [XW-1:0] y_next;
    logic signed [ZW-1:0] z_next;

    if (s == 0) begin : g_first
      assign x_cur   = x_in;
      assign y_cur   = y_in;
      assign z_cur   = z_in;
      assign vld_in  = in_valid;
      assign side_in = in_side;
    end else begin : g_next
      assign x_cur   = x_q[s-1];
      assign y_cur   = y_q[s-1];
      assign z_cur   = z_q[s-1];
      assign vld_in  = vld_q[s-1];
      assign side_in = side_q[s-1];
    end

    always_comb begin
      logic signed [XW-1:0] dxv;
      logic signed [XW-1:0] dyv;
      x_next = x_cur;
      y_next = y_cur;
      z_next = z_cur;
      for (int j = 0; j < PER; j++) begin
        dxv = y_next >>> (s * PER + j);
        dyv = x_next >>> (s * PER + j);
        if (y_next > 0) begin
          x_next = x_next + dxv;
          y_next = y_next - dyv;
          z_next = z_next + dihed_pkg::atan_q32(5'(s * PER + j));
        end else begin
          x_next = x_next - dxv;
          y_next = y_next + dyv;
          z_next = z_next - dihed_pkg::atan_q32(5'(s * PER + j));
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      z_q[s]    <= z_next;
      side_q[s] <= side_in;
    end

    if (s < STAGES - 1) begin : g_xy
      always_ff @(posedge clk) begin
        x_q[s] <= x_next;
        y_q[s] <= y_next;
      end
    end
  end

  assign out_valid = vld_q[STAGES-1];
  assign z_out     = z_q[STAGES-1];
  assign out_side  = side_q[STAGES-1];

endmodule

FILE: verif/tb_dihedral_angle_four_points_core.sv
// testbench for the four-point torsion angle core: directed and random beats against a predictor
`timescale 1ns / 1ps

module tb_dihedral_angle_four_points_core;

  typedef logic signed [31:0] coord_t;
  typedef coord_t pts_t [12];

  typedef struct {
    logic signed [19:0] torsion;
    logic               degenerate;
  } angle_t;

  localparam longint PI_Q32      = 64'sd13493037704;
  localparam int     WATCH_LIMIT = 2000;
  localparam int     DRAIN       = 40;

  // atan(2^-i) in q32
  localparam longint ATAN_TAB [32] = '{
    64'sd3373259426, 1991351318, 1052175346, 534100635, 268086748, 134174063,
    67103403, 33553749, 16777131, 8388597, 4194303, 2097152, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128,
    64, 32, 16, 8, 4, 2};

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   start = 1'b0;
  logic   busy;
  coord_t ax = '0, ay = '0, az = '0, bx = '0, by = '0, bz = '0;
  coord_t cx = '0, cy = '0, cz = '0, dx = '0, dy = '0, dz = '0;
  logic   done;
  logic signed [19:0] torsion;
  logic   degenerate;

  angle_t angle_q[$];
  int     mismatches = 0;
  int     idle_pct = 0;
  int     watch_cnt = 0;

  dihedral_angle_four_points_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .ax(ax), .ay(ay), .az(az), .bx(bx), .by(by), .bz(bz),
    .cx(cx), .cy(cy), .cz(cz), .dx(dx), .dy(dy), .dz(dz),
    .done(done), .torsion(torsion), .degenerate(degenerate)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // arithmetic shift on a signed value is a floor shift
  function automatic longint fshr(input longint v, input int s);
    if (s > 62) s = 62;
    return v >>> s;
  endfunction

  function automatic longint unsigned mag(input longint v);
    return v < 0 ? -v : v;
  endfunction

  // rescale by one power of two so the largest magnitude has target bits
  function automatic void rescale(inout longint v[3], input int target);
    longint unsigned m;
    int len;
    m = 0;
    for (int i = 0; i < 3; i++) if (mag(v[i]) > m) m = mag(v[i]);
    len = 0;
    while (m != 0) begin len++; m = m >> 1; end
    if (len == 0) return;
    for (int i = 0; i < 3; i++)
      if (len > target) v[i] = fshr(v[i], len - target);
      else v[i] = v[i] * (64'sd1 <<< (target - len));
  endfunction

  function automatic void cross3(input longint p[3], input longint q[3], output longint r[3]);
    r[0] = p[1] * q[2] - p[2] * q[1];
    r[1] = p[2] * q[0] - p[0] * q[2];
    r[2] = p[0] * q[1] - p[1] * q[0];
  endfunction

  function automatic longint dot(input longint p[3], input longint q[3]);
    return p[0] * q[0] + p[1] * q[1] + p[2] * q[2];
  endfunction

  function automatic bit all_zero(input longint p[3]);
    return p[0] == 0 && p[1] == 0 && p[2] == 0;
  endfunction

  function automatic longint unsigned root64(input longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin x = x - (res + b); res = (res >> 1) + b; end
      else res = res >> 1;
      b = b >> 2;
    end
    return res;
  endfunction

  // vectoring cordic, q32 angle; y zero with x negative gives +pi
  function automatic longint cordic_atan2(input longint y, input longint x);
    longint pr[3];
    longint z, sx, sy;
    if (y == 0) return x < 0 ? PI_Q32 : 0;
    pr = '{x, y, 0};
    rescale(pr, 29);
    x = pr[0];
    y = pr[1];
    z = 0;
    if (x < 0) begin
      z = y >= 0 ? PI_Q32 : -PI_Q32;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 32; i++) begin
      sx = fshr(y, i);
      sy = fshr(x, i);
      if (y > 0) begin x += sx; y -= sy; z += ATAN_TAB[i]; end
      else begin x -= sx; y += sy; z -= ATAN_TAB[i]; end
    end
    if (z > PI_Q32) z = PI_Q32;
    if (z < -PI_Q32) z = -PI_Q32;
    return z;
  endfunction

  function automatic angle_t torsion_of(input pts_t pts);
    longint b1[3], b2[3], b3[3], u[3], v[3], w[3];
    longint num, den, ang;
    angle_t r;
    for (int i = 0; i < 3; i++) begin
      b1[i] = longint'(pts[3 + i]) - longint'(pts[i]);
      b2[i] = longint'(pts[6 + i]) - longint'(pts[3 + i]);
      b3[i] = longint'(pts[9 + i]) - longint'(pts[6 + i]);
    end
    r.torsion = '0;
    r.degenerate = 1'b1;
    if (all_zero(b1) || all_zero(b2) || all_zero(b3)) return r;
    rescale(b1, 20);
    rescale(b2, 20);
    rescale(b3, 20);
    cross3(b1, b2, u);
    cross3(b2, b3, v);
    if (all_zero(u) || all_zero(v)) return r;
    rescale(u, 20);
    rescale(v, 20);
    cross3(u, v, w);
    num = dot(w, b2);
    den = dot(u, v) * longint'(root64(dot(b2, b2)));
    ang = fshr(cordic_atan2(num, den) + (64'sd1 <<< 14), 15);
    r.torsion = ang[19:0];
    r.degenerate = 1'b0;
    return r;
  endfunction

  // drive one beat, hold it until taken, then queue its angle
  task automatic send_points(input pts_t pts);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    {ax, ay, az} <= {pts[0], pts[1], pts[2]};
    {bx, by, bz} <= {pts[3], pts[4], pts[5]};
    {cx, cy, cz} <= {pts[6], pts[7], pts[8]};
    {dx, dy, dz} <= {pts[9], pts[10], pts[11]};
    @(posedge clk);
    while (busy) @(posedge clk);
    angle_q.push_back(torsion_of(pts));
  endtask

  function automatic pts_t pts_of(input int p[12]);
    pts_t r;
    for (int i = 0; i < 12; i++) r[i] = p[i] <<< 16;
    return r;
  endfunction

  task automatic test_degenerate();
    send_points(pts_of('{0,0,0, 0,0,0, 1,0,0, 1,1,0}));   // a on b
    send_points(pts_of('{0,0,0, 1,0,0, 1,0,0, 1,1,0}));   // b on c
    send_points(pts_of('{0,0,0, 1,0,0, 2,0,0, 2,0,0}));   // c on d
    send_points(pts_of('{0,0,0, 1,1,1, 2,2,2, 2,3,0}));   // a b c in line
    send_points(pts_of('{0,1,0, 0,0,0, 1,0,0, 3,0,0}));   // b c d in line
    send_points('{default: 32'sd0});
  endtask

  task automatic test_planar();
    send_points(pts_of('{0,1,0, 0,0,0, 1,0,0, 1,1,0}));   // cis, zero angle
    send_points(pts_of('{0,1,0, 0,0,0, 1,0,0, 1,-1,0}));  // trans, pi
    send_points(pts_of('{0,1,0, 0,0,0, 1,0,0, 1,0,1}));   // plus quarter turn
    send_points(pts_of('{0,1,0, 0,0,0, 1,0,0, 1,0,-1}));  // minus quarter turn
    send_points(pts_of('{1,1,0, 0,0,0, 1,0,0, 2,-1,1}));
  endtask

  task automatic test_extremes();
    pts_t p;
    p = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
          32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
          32'h80000000, 32'h7fffffff};
    send_points(p);
    p = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
          32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
          32'h7fffffff, 32'h7fffffff};
    send_points(p);
    p = '{32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd1,
          32'sd0, 32'sd0, 32'sd1, 32'sd1};
    send_points(p);
    p = '{32'hffffffff, 32'hffffffff, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
          32'h7fffffff, 32'sd0, 32'sd0, 32'h7fffffff, 32'sd1, 32'hffffffff};
    send_points(p);
  endtask

  // mostly well-formed geometry at random scales, plus duplicate, in-line and coplanar points
  task automatic test_random(input int n);
    pts_t p;
    int kind, sh;
    for (int k = 0; k < n; k++) begin
      kind = $urandom_range(99);
      sh = $urandom_range(31);
      for (int i = 0; i < 12; i++) p[i] = coord_t'($urandom) >>> sh;
      if (kind < 10) begin
        for (int i = 0; i < 3; i++) p[3 * $urandom_range(2, 3) + i] = p[3 + i];
      end else if (kind < 20) begin
        for (int i = 0; i < 3; i++) begin
          p[6 + i] = p[3 + i] + (p[3 + i] - p[i]);
          if (kind >= 15) p[9 + i] = p[6 + i] + (p[6 + i] - p[3 + i]);
        end
      end else if (kind < 25) begin
        p[2] = p[5];
        p[8] = p[5];
        p[11] = p[5];
      end
      send_points(p);
    end
  endtask

  // results come as one-cycle strobes; the oldest expectation must match
  always @(posedge clk) begin
    if (!rst && done) begin
      if (angle_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: torsion %0d degenerate %0d",
                                       torsion, degenerate);
      end else if (angle_q[0].torsion !== torsion
                   || angle_q[0].degenerate !== degenerate) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected torsion %0d degenerate %0d, got %0d %0d",
                   angle_q[0].torsion, angle_q[0].degenerate, torsion, degenerate);
        void'(angle_q.pop_front());
      end else begin
        void'(angle_q.pop_front());
      end
    end
  end

  // watchdog on cycles with no beat either way
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) watch_cnt <= 0;
    else watch_cnt <= watch_cnt + 1;
    if (watch_cnt >= WATCH_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    idle_pct = 33;
    test_degenerate();
    test_planar();
    test_extremes();
    test_random(330);
    idle_pct = 65;
    test_random(330);
    idle_pct = 0;
    test_random(340);
    start <= 1'b0;
    while (angle_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0 && angle_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/dihed_pkg.sv
sv/dihed_scale.sv
sv/dihed_isqrt.sv
sv/dihed_cordic.sv
sv/dihedral_angle_four_points_core.sv
verif/tb_dihedral_angle_four_points_core.sv
